>>> hdl/rv32is_pkg.sv
// ----------------------------------------------------------------------------
// rv32is_pkg
// Shared constants, opcodes, state encoding and controller/datapath
// command and status structs for the RV32IM instruction step block.
// ----------------------------------------------------------------------------
package rv32is_pkg;

  localparam int unsigned MEM_BYTES_DEF = 65536;
  localparam int unsigned DIV_STEPS     = 32;

  localparam logic [31:0] NOP_WORD   = 32'h0000_0013;
  localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;
  localparam logic [31:0] ALL_ONES   = 32'hffff_ffff;
  localparam logic [31:0] UPPER_MASK = 32'hffff_f000;

  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_IMM    = 7'h13;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;

  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [6:0] F7_ALT    = 7'h20;

  // ALU funct3
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  // M extension funct3
  localparam logic [2:0] F3_MUL    = 3'd0;
  localparam logic [2:0] F3_MULH   = 3'd1;
  localparam logic [2:0] F3_MULHSU = 3'd2;
  localparam logic [2:0] F3_MULHU  = 3'd3;
  localparam logic [2:0] F3_DIV    = 3'd4;
  localparam logic [2:0] F3_DIVU   = 3'd5;
  localparam logic [2:0] F3_REM    = 3'd6;
  localparam logic [2:0] F3_REMU   = 3'd7;
  // load / store funct3
  localparam logic [2:0] F3_B  = 3'd0;
  localparam logic [2:0] F3_H  = 3'd1;
  localparam logic [2:0] F3_W  = 3'd2;
  localparam logic [2:0] F3_BU = 3'd4;
  localparam logic [2:0] F3_HU = 3'd5;
  // branch funct3
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  typedef enum logic [1:0] {
    OP_STEP,
    OP_PRELOAD,
    OP_SETREG,
    OP_SETPC
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RS1,
    S_RS2,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_LOAD,
    S_STORE,
    S_WB
  } state_t;

  typedef struct packed {
    logic accept;
    logic clr_run;
    logic rf_rd1;
    logic rf_rd2;
    logic exec;
    logic mul_fin;
    logic div_run;
    logic ld_run;
    logic st_run;
    logic wb;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_step;
    logic is_mul;
    logic is_div;
    logic is_load;
    logic is_store;
    logic div_done;
    logic seq_done;
    logic out_free;
  } dp_status_t;

endpackage

>>> hdl/rv32im_instruction_step.sv
// ----------------------------------------------------------------------------
// rv32im_instruction_step
// Executes one RV32IM instruction per step transfer and emits a retire trace.
//
// Input channel (in_*): op 0 steps the word in in_instr (a no-op if
// in_instr_present is low), op 1 preloads a little-endian memory word at
// in_addr, op 2 writes a register, op 3 sets the pc. Only op 0 produces a
// transfer on the output channel (out_*).
// Flow of a step: ALU, branch and jump instructions pass through two register
// file reads, execute and commit; multiplies add a multiply stage, loads read
// one byte a cycle from the byte-wide data RAM, stores write their bytes the
// same way, and divides run the radix-2 divider. Preload keeps the block busy
// while it writes its four bytes; set register and set pc complete in the
// accepting cycle. One item is in work at a time.
// After reset the data memory is swept to zero with in_ready low.
// MEM_BYTES must be a power of two.
// The output register holds a finished trace; the next item may be accepted
// while it waits, but that item will not commit until out_ready frees it.
// ----------------------------------------------------------------------------
module rv32im_instruction_step #(
  parameter int unsigned MEM_BYTES = rv32is_pkg::MEM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_instr,
  input  logic        in_instr_present,
  input  logic [31:0] in_addr,
  input  logic [4:0]  in_reg_index,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_retired_pc,
  output logic [31:0] out_retired_instr,
  output logic        out_rd_write,
  output logic [4:0]  out_rd_index,
  output logic [31:0] out_rd_data,
  output logic        out_mem_read,
  output logic        out_mem_write,
  output logic [31:0] out_mem_addr,
  output logic [31:0] out_mem_rdata,
  output logic [31:0] out_mem_wdata,
  output logic [3:0]  out_write_strobe,
  output logic [31:0] out_next_pc
);

  rv32is_pkg::dp_cmd_t    cmd;
  rv32is_pkg::dp_status_t st;

  rv32is_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  rv32is_dp #(.MEM_BYTES(MEM_BYTES)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .in_op             (in_op),
    .in_instr          (in_instr),
    .in_instr_present  (in_instr_present),
    .in_addr           (in_addr),
    .in_reg_index      (in_reg_index),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_retired_pc    (out_retired_pc),
    .out_retired_instr (out_retired_instr),
    .out_rd_write      (out_rd_write),
    .out_rd_index      (out_rd_index),
    .out_rd_data       (out_rd_data),
    .out_mem_read      (out_mem_read),
    .out_mem_write     (out_mem_write),
    .out_mem_addr      (out_mem_addr),
    .out_mem_rdata     (out_mem_rdata),
    .out_mem_wdata     (out_mem_wdata),
    .out_write_strobe  (out_write_strobe),
    .out_next_pc       (out_next_pc)
  );

  a_rd0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rd_index == 5'd0 |-> out_rd_data == 32'd0)
    else $error("register 0 result not zero");

  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rd_write |-> out_rd_data == 32'd0)
    else $error("result data without register write");

  a_rw_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_mem_read && out_mem_write))
    else $error("load and store flagged together");

  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_mem_write |-> out_write_strobe == 4'd0)
    else $error("strobe without store");

endmodule

>>> hdl/rv32is_ram.sv
// ----------------------------------------------------------------------------
// rv32is_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rv32is_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/rv32is_ctrl.sv
// ----------------------------------------------------------------------------
// rv32is_ctrl
// Sequencer for the instruction step block: memory clear after reset,
// operand reads, execute, multi-cycle units, memory byte sequencing, commit.
// ----------------------------------------------------------------------------
module rv32is_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [1:0]             in_op,
  output logic                   in_ready,
  input  rv32is_pkg::dp_status_t st,
  output rv32is_pkg::dp_cmd_t    cmd
);

  rv32is_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rv32is_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rv32is_pkg::S_CLEAR: begin
        if (st.clr_done) state_nxt = rv32is_pkg::S_IDLE;
      end
      rv32is_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_op == rv32is_pkg::OP_STEP) begin
            state_nxt = rv32is_pkg::S_RS1;
          end else if (in_op == rv32is_pkg::OP_PRELOAD) begin
            state_nxt = rv32is_pkg::S_STORE;
          end
        end
      end
      rv32is_pkg::S_RS1: state_nxt = rv32is_pkg::S_RS2;
      rv32is_pkg::S_RS2: state_nxt = rv32is_pkg::S_EXEC;
      rv32is_pkg::S_EXEC: begin
        if (st.is_mul) state_nxt = rv32is_pkg::S_MUL;
        else if (st.is_div) state_nxt = rv32is_pkg::S_DIV;
        else if (st.is_load) state_nxt = rv32is_pkg::S_LOAD;
        else if (st.is_store) state_nxt = rv32is_pkg::S_STORE;
        else state_nxt = rv32is_pkg::S_WB;
      end
      rv32is_pkg::S_MUL: state_nxt = rv32is_pkg::S_WB;
      rv32is_pkg::S_DIV: begin
        if (st.div_done) state_nxt = rv32is_pkg::S_WB;
      end
      rv32is_pkg::S_LOAD: begin
        if (st.seq_done) state_nxt = rv32is_pkg::S_WB;
      end
      rv32is_pkg::S_STORE: begin
        // preload transfers end here without a result
        if (st.seq_done) state_nxt = st.is_step ? rv32is_pkg::S_WB : rv32is_pkg::S_IDLE;
      end
      rv32is_pkg::S_WB: begin
        if (st.out_free) state_nxt = rv32is_pkg::S_IDLE;
      end
      default: state_nxt = rv32is_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      rv32is_pkg::S_CLEAR: cmd.clr_run = 1'b1;
      rv32is_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      rv32is_pkg::S_RS1:   cmd.rf_rd1  = 1'b1;
      rv32is_pkg::S_RS2:   cmd.rf_rd2  = 1'b1;
      rv32is_pkg::S_EXEC:  cmd.exec    = 1'b1;
      rv32is_pkg::S_MUL:   cmd.mul_fin = 1'b1;
      rv32is_pkg::S_DIV:   cmd.div_run = 1'b1;
      rv32is_pkg::S_LOAD:  cmd.ld_run  = 1'b1;
      rv32is_pkg::S_STORE: cmd.st_run  = 1'b1;
      rv32is_pkg::S_WB:    cmd.wb      = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

>>> hdl/rv32is_dp.sv
// ----------------------------------------------------------------------------
// rv32is_dp
// Datapath: pc, register file RAM with valid bits, byte-wide data memory,
// ALU, registered multiplier, radix-2 divider, load/store byte sequencer and
// the retire output register.
// ----------------------------------------------------------------------------
module rv32is_dp #(
  parameter int unsigned MEM_BYTES = rv32is_pkg::MEM_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rv32is_pkg::dp_cmd_t    cmd,
  output rv32is_pkg::dp_status_t st,
  input  logic [1:0]             in_op,
  input  logic [31:0]            in_instr,
  input  logic                   in_instr_present,
  input  logic [31:0]            in_addr,
  input  logic [4:0]             in_reg_index,
  input  logic [31:0]            in_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [31:0]            out_retired_pc,
  output logic [31:0]            out_retired_instr,
  output logic                   out_rd_write,
  output logic [4:0]             out_rd_index,
  output logic [31:0]            out_rd_data,
  output logic                   out_mem_read,
  output logic                   out_mem_write,
  output logic [31:0]            out_mem_addr,
  output logic [31:0]            out_mem_rdata,
  output logic [31:0]            out_mem_wdata,
  output logic [3:0]             out_write_strobe,
  output logic [31:0]            out_next_pc
);

  // MEM_BYTES must be a power of two, which the block does not enforce; byte addresses wrap by masking
  localparam int unsigned AW = $clog2(MEM_BYTES);

  logic [1:0]  op_r;
  logic [31:0] word_r, pc_r, a_r, res_r, npc_r, ea_r, mrdata_r, mwdata_r, mdata_r;
  logic        wr_r, rdf_r, wtf_r;
  logic [3:0]  strobe_r;
  logic [2:0]  len_r, cnt_r;
  logic [AW-1:0] base_r;
  logic [AW:0]   clr_cnt_r;
  logic signed [65:0] prod_r;
  logic [31:0] dq_r, drem_r, ddiv_r, spec_res_r;
  logic [5:0]  dcnt_r;
  logic        negq_r, negr_r, spec_r;
  logic [31:0] rf_vld_r;
  logic        rf_vld_q;
  logic        out_valid_r;

  // decode
  logic [6:0]  opc, f7;
  logic [4:0]  rd, rs1, rs2;
  logic [2:0]  f3;
  logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
  assign opc   = word_r[6:0];
  assign rd    = word_r[11:7];
  assign f3    = word_r[14:12];
  assign rs1   = word_r[19:15];
  assign rs2   = word_r[24:20];
  assign f7    = word_r[31:25];
  assign imm_i = {{20{word_r[31]}}, word_r[31:20]};
  assign imm_s = {{20{word_r[31]}}, word_r[31:25], word_r[11:7]};
  assign imm_b = {{19{word_r[31]}}, word_r[31], word_r[7], word_r[30:25], word_r[11:8], 1'b0};
  assign imm_j = {{11{word_r[31]}}, word_r[31], word_r[19:12], word_r[20], word_r[30:21],
                  1'b0};
  assign imm_u = word_r & rv32is_pkg::UPPER_MASK;

  logic is_muldiv, commit, out_free, seq_done, div_done;
  assign is_muldiv = (opc == rv32is_pkg::OPC_OP) && (f7 == rv32is_pkg::F7_MULDIV);
  assign out_free  = !out_valid_r || out_ready;
  assign commit    = cmd.wb && out_free;
  assign seq_done  = (cnt_r == len_r);
  assign div_done  = (dcnt_r == 6'(rv32is_pkg::DIV_STEPS));

  assign st.clr_done = clr_cnt_r[AW];
  assign st.is_step  = (op_r == rv32is_pkg::OP_STEP);
  assign st.is_mul   = is_muldiv && !f3[2];
  assign st.is_div   = is_muldiv && f3[2];
  assign st.is_load  = (opc == rv32is_pkg::OPC_LOAD);
  assign st.is_store = (opc == rv32is_pkg::OPC_STORE);
  assign st.div_done = div_done;
  assign st.seq_done = seq_done;
  assign st.out_free = out_free;

  // ---------------- register file ----------------
  logic        rf_we;
  logic [4:0]  rf_waddr, rf_raddr;
  logic [31:0] rf_wdata, rf_rdata, rf_q, res_fin;

  assign rf_raddr = cmd.rf_rd2 ? rs2 : rs1;
  assign rf_q     = rf_vld_q ? rf_rdata : 32'd0;

  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = rd;
    rf_wdata = res_fin;
    if (cmd.accept && in_op == rv32is_pkg::OP_SETREG && in_reg_index != 5'd0) begin
      rf_we    = 1'b1;
      rf_waddr = in_reg_index;
      rf_wdata = in_value;
    end else if (commit && wr_r && rd != 5'd0) begin
      rf_we = 1'b1;
    end
  end

  rv32is_ram #(.WIDTH(32), .DEPTH(32)) u_rf (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_raddr),
    .rdata (rf_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
      rf_vld_q <= 1'b0;
    end else begin
      rf_vld_q <= rf_vld_r[rf_raddr];
      if (rf_we) rf_vld_r[rf_waddr] <= 1'b1;
    end
  end

  // ---------------- data memory ----------------
  logic          dm_we;
  logic [AW-1:0] dm_waddr, seq_addr;
  logic [7:0]    dm_wdata, dm_rdata;
  logic [1:0]    ld_idx;

  assign seq_addr = base_r + AW'(cnt_r);
  assign ld_idx   = 2'(cnt_r - 3'd1);
  assign dm_we    = (cmd.clr_run && !clr_cnt_r[AW]) || (cmd.st_run && !seq_done);
  assign dm_waddr = cmd.clr_run ? clr_cnt_r[AW-1:0] : seq_addr;
  assign dm_wdata = cmd.clr_run ? 8'd0 : mdata_r[{cnt_r[1:0], 3'b000} +: 8];

  rv32is_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .raddr (seq_addr),
    .rdata (dm_rdata)
  );

  // ---------------- execute ----------------
  logic [31:0] ex_res, ex_npc, ex_ea, ex_mwd, sum_jalr;
  logic        ex_wr, ex_rdf, ex_wtf, taken;
  logic [3:0]  ex_strobe;
  logic [2:0]  ex_len;
  logic [4:0]  sh;

  assign sum_jalr = a_r + imm_i;

  always_comb begin
    ex_res    = 32'd0;
    ex_wr     = 1'b0;
    ex_npc    = pc_r + 32'd4;
    ex_ea     = 32'd0;
    ex_mwd    = 32'd0;
    ex_rdf    = 1'b0;
    ex_wtf    = 1'b0;
    ex_strobe = 4'd0;
    ex_len    = 3'd0;
    taken     = 1'b0;
    sh        = rf_q[4:0];
    case (opc)
      rv32is_pkg::OPC_OP: begin
        ex_wr = 1'b1;
        if (f7 == rv32is_pkg::F7_MULDIV) begin
          ex_res = 32'd0;  // filled by multiplier or divider
        end else if (f7 == rv32is_pkg::F7_ALT) begin
          if (f3 == rv32is_pkg::F3_ADD) ex_res = a_r - rf_q;
          else if (f3 == rv32is_pkg::F3_SR) ex_res = 32'($signed(a_r) >>> sh);
          else ex_wr = 1'b0;
        end else begin
          case (f3)
            rv32is_pkg::F3_ADD:  ex_res = a_r + rf_q;
            rv32is_pkg::F3_SLL:  ex_res = a_r << sh;
            rv32is_pkg::F3_SLT:  ex_res = {31'd0, $signed(a_r) < $signed(rf_q)};
            rv32is_pkg::F3_SLTU: ex_res = {31'd0, a_r < rf_q};
            rv32is_pkg::F3_XOR:  ex_res = a_r ^ rf_q;
            rv32is_pkg::F3_SR:   ex_res = a_r >> sh;
            rv32is_pkg::F3_OR:   ex_res = a_r | rf_q;
            default:             ex_res = a_r & rf_q;
          endcase
        end
      end
      rv32is_pkg::OPC_IMM: begin
        ex_wr = 1'b1;
        sh    = word_r[24:20];
        case (f3)
          rv32is_pkg::F3_ADD:  ex_res = a_r + imm_i;
          rv32is_pkg::F3_SLL:  ex_res = a_r << sh;
          rv32is_pkg::F3_SLT:  ex_res = {31'd0, $signed(a_r) < $signed(imm_i)};
          rv32is_pkg::F3_SLTU: ex_res = {31'd0, a_r < imm_i};
          rv32is_pkg::F3_XOR:  ex_res = a_r ^ imm_i;
          rv32is_pkg::F3_SR: begin
            ex_res = (f7 == rv32is_pkg::F7_ALT) ? 32'($signed(a_r) >>> sh) : (a_r >> sh);
          end
          rv32is_pkg::F3_OR:   ex_res = a_r | imm_i;
          default:             ex_res = a_r & imm_i;
        endcase
      end
      rv32is_pkg::OPC_LOAD: begin
        ex_ea  = a_r + imm_i;
        ex_len = 3'd4;  // the full word is always read for the trace
        case (f3)
          rv32is_pkg::F3_B, rv32is_pkg::F3_H, rv32is_pkg::F3_W,
          rv32is_pkg::F3_BU, rv32is_pkg::F3_HU: begin
            ex_wr  = 1'b1;
            ex_rdf = 1'b1;
          end
          default: ex_wr = 1'b0;
        endcase
      end
      rv32is_pkg::OPC_STORE: begin
        ex_ea  = a_r + imm_s;
        ex_mwd = rf_q;
        case (f3)
          rv32is_pkg::F3_B: begin
            ex_wtf = 1'b1; ex_strobe = 4'd1; ex_len = 3'd1;
          end
          rv32is_pkg::F3_H: begin
            ex_wtf = 1'b1; ex_strobe = 4'd3; ex_len = 3'd2;
          end
          rv32is_pkg::F3_W: begin
            ex_wtf = 1'b1; ex_strobe = 4'd15; ex_len = 3'd4;
          end
          default: ex_wtf = 1'b0;
        endcase
      end
      rv32is_pkg::OPC_BRANCH: begin
        case (f3)
          rv32is_pkg::F3_BEQ:  taken = (a_r == rf_q);
          rv32is_pkg::F3_BNE:  taken = (a_r != rf_q);
          rv32is_pkg::F3_BLT:  taken = ($signed(a_r) < $signed(rf_q));
          rv32is_pkg::F3_BGE:  taken = !($signed(a_r) < $signed(rf_q));
          rv32is_pkg::F3_BLTU: taken = (a_r < rf_q);
          rv32is_pkg::F3_BGEU: taken = (a_r >= rf_q);
          default:             taken = 1'b0;
        endcase
        if (taken) ex_npc = pc_r + imm_b;
      end
      rv32is_pkg::OPC_JAL: begin
        ex_res = pc_r + 32'd4;
        ex_wr  = 1'b1;
        ex_npc = pc_r + imm_j;
      end
      rv32is_pkg::OPC_JALR: begin
        ex_res = pc_r + 32'd4;
        ex_wr  = 1'b1;
        ex_npc = {sum_jalr[31:1], 1'b0};
      end
      rv32is_pkg::OPC_LUI: begin
        ex_res = imm_u;
        ex_wr  = 1'b1;
      end
      rv32is_pkg::OPC_AUIPC: begin
        ex_res = pc_r + imm_u;
        ex_wr  = 1'b1;
      end
      default: ex_wr = 1'b0;
    endcase
  end

  // multiplier operand signs
  logic sa, sb, dsgn;
  assign sa   = (f3 == rv32is_pkg::F3_MULH || f3 == rv32is_pkg::F3_MULHSU) && a_r[31];
  assign sb   = (f3 == rv32is_pkg::F3_MULH) && rf_q[31];
  assign dsgn = !f3[0];

  // divider step
  logic [32:0] rem_sh;
  logic [33:0] dsub;
  logic        dge;
  assign rem_sh = {drem_r, dq_r[31]};
  assign dsub   = {1'b0, rem_sh} - {2'b00, ddiv_r};
  assign dge    = !dsub[33];

  // load formatting
  logic [31:0] ld_fmt;
  always_comb begin
    case (f3)
      rv32is_pkg::F3_B:  ld_fmt = {{24{mrdata_r[7]}}, mrdata_r[7:0]};
      rv32is_pkg::F3_H:  ld_fmt = {{16{mrdata_r[15]}}, mrdata_r[15:0]};
      rv32is_pkg::F3_W:  ld_fmt = mrdata_r;
      rv32is_pkg::F3_BU: ld_fmt = {24'd0, mrdata_r[7:0]};
      rv32is_pkg::F3_HU: ld_fmt = {16'd0, mrdata_r[15:0]};
      default:           ld_fmt = 32'd0;
    endcase
  end
  assign res_fin = !wr_r ? 32'd0 : (st.is_load ? ld_fmt : res_r);

  // ---------------- sequential datapath ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= 32'd0;
      op_r      <= rv32is_pkg::OP_STEP;
      clr_cnt_r <= '0;
      cnt_r     <= 3'd0;
      len_r     <= 3'd0;
      dcnt_r    <= 6'd0;
    end else begin
      if (cmd.clr_run && !clr_cnt_r[AW]) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.accept) begin
        op_r   <= in_op;
        word_r <= in_instr_present ? in_instr : rv32is_pkg::NOP_WORD;
        base_r <= in_addr[AW-1:0];
        mdata_r <= in_value;
        len_r  <= 3'd4;
        cnt_r  <= 3'd0;
        if (in_op == rv32is_pkg::OP_SETPC) pc_r <= in_value;
      end
      if (cmd.rf_rd2) a_r <= rf_q;
      if (cmd.exec) begin
        res_r    <= ex_res;
        wr_r     <= ex_wr;
        npc_r    <= ex_npc;
        ea_r     <= ex_ea;
        rdf_r    <= ex_rdf;
        wtf_r    <= ex_wtf;
        strobe_r <= ex_strobe;
        len_r    <= ex_len;
        mwdata_r <= ex_mwd;
        mdata_r  <= rf_q;
        base_r   <= ex_ea[AW-1:0];
        cnt_r    <= 3'd0;
        mrdata_r <= 32'd0;
        prod_r   <= $signed({sa, a_r}) * $signed({sb, rf_q});
        dq_r     <= (dsgn && a_r[31]) ? (32'd0 - a_r) : a_r;
        ddiv_r   <= (dsgn && rf_q[31]) ? (32'd0 - rf_q) : rf_q;
        drem_r   <= 32'd0;
        dcnt_r   <= 6'd0;
        negq_r   <= dsgn && (a_r[31] ^ rf_q[31]);
        negr_r   <= dsgn && a_r[31];
        if (rf_q == 32'd0) begin
          spec_r     <= 1'b1;
          spec_res_r <= f3[1] ? a_r : rv32is_pkg::ALL_ONES;
        end else if (dsgn && a_r == rv32is_pkg::SIGN_BIT && rf_q == rv32is_pkg::ALL_ONES) begin
          spec_r     <= 1'b1;
          spec_res_r <= f3[1] ? 32'd0 : rv32is_pkg::SIGN_BIT;
        end else begin
          spec_r     <= 1'b0;
          spec_res_r <= 32'd0;
        end
      end
      if (cmd.mul_fin) begin
        res_r <= (f3 == rv32is_pkg::F3_MUL) ? prod_r[31:0] : prod_r[63:32];
      end
      if (cmd.div_run) begin
        if (!div_done) begin
          drem_r <= dge ? dsub[31:0] : rem_sh[31:0];
          dq_r   <= {dq_r[30:0], dge};
          dcnt_r <= dcnt_r + 6'd1;
        end else if (spec_r) begin
          res_r <= spec_res_r;
        end else if (f3[1]) begin
          res_r <= negr_r ? (32'd0 - drem_r) : drem_r;
        end else begin
          res_r <= negq_r ? (32'd0 - dq_r) : dq_r;
        end
      end
      if ((cmd.ld_run || cmd.st_run) && !seq_done) cnt_r <= cnt_r + 3'd1;
      // read data arrives from the registered RAM port in the cycle after its address
      if (cmd.ld_run && cnt_r != 3'd0) mrdata_r[{ld_idx, 3'b000} +: 8] <= dm_rdata;
      if (commit) pc_r <= npc_r;
    end
  end

  // ---------------- retire output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_retired_pc    <= pc_r;
      out_retired_instr <= word_r;
      out_rd_write      <= wr_r;
      out_rd_index      <= rd;
      out_rd_data       <= (rd == 5'd0) ? 32'd0 : res_fin;
      out_mem_read      <= rdf_r;
      out_mem_write     <= wtf_r;
      out_mem_addr      <= ea_r;
      out_mem_rdata     <= mrdata_r;
      out_mem_wdata     <= mwdata_r;
      out_write_strobe  <= strobe_r;
      out_next_pc       <= npc_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule
